>>> hdl/msf2f_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msf2f_pkg
// Types, constants and the microcode table of the F2F track encoder.
// ----------------------------------------------------------------------------
package msf2f_pkg;

   localparam int CHAR_W      = 7;
   localparam int WORD_W      = 6;
   localparam int CNT_W       = 5;
   localparam int STEP_W      = 4;
   localparam int TRAIL_ZEROS = 25;

   // track one: 6 data bits, offset 32; track two: 4 data bits, offset 48
   localparam logic [CHAR_W-1:0] OFFSET_T1 = 7'd32;
   localparam logic [CHAR_W-1:0] OFFSET_T2 = 7'd48;
   localparam logic [WORD_W-1:0] MASK_T1   = 6'h3F;
   localparam logic [WORD_W-1:0] MASK_T2   = 6'h0F;
   localparam logic [CNT_W-1:0]  NBITS_T1  = 5'd6;
   localparam logic [CNT_W-1:0]  NBITS_T2  = 5'd4;

   typedef enum logic [STEP_W-1:0] {
      STEP_IDLE  = 4'd0,
      STEP_START = 4'd1,
      STEP_PRE   = 4'd2,
      STEP_LOADC = 4'd3,
      STEP_BITS  = 4'd4,
      STEP_PAR   = 4'd5,
      STEP_LOADL = 4'd6,
      STEP_LBITS = 4'd7,
      STEP_LPAR  = 4'd8,
      STEP_TRAIL = 4'd9,
      STEP_END   = 4'd10
   } step_type;

   typedef enum logic [1:0] {
      BIT_ZERO   = 2'd0,
      BIT_WORD   = 2'd1,
      BIT_PARITY = 2'd2
   } bit_src_type;

   typedef enum logic [1:0] {
      CNT_NONE  = 2'd0,
      CNT_LEAD  = 2'd1,
      CNT_NBITS = 2'd2,
      CNT_TRAIL = 2'd3
   } cnt_src_type;

   typedef enum logic [1:0] {
      WORD_NONE = 2'd0,
      WORD_CHAR = 2'd1,
      WORD_LRC  = 2'd2
   } word_src_type;

   typedef enum logic [1:0] {
      COND_ALWAYS   = 2'd0,
      COND_IN_TRACK = 2'd1,
      COND_CNT_NZ   = 2'd2,
      COND_NOT_LAST = 2'd3
   } cond_type;

   // one control word
   typedef struct packed {
      logic         wait_req;   // step holds until an input beat arrives
      logic         emit;       // step sends one bit cell
      bit_src_type  bit_src;
      cnt_src_type  cnt_load;
      word_src_type word_load;
      logic         start;      // new track: clear coil and LRC
      logic         finish;     // track over: release
      logic         done_at_end;
      cond_type     cond;
      step_type     target;     // jump when cond holds, else fall through
   } ctl_type;

   // status fed back to the sequencer
   typedef struct packed {
      logic accept;
      logic in_track;
      logic cnt_nz;
      logic last;
      logic out_free;
   } flags_type;

   function automatic ctl_type ucode(input step_type step);
      ctl_type c;
      c.wait_req    = 1'b0;
      c.emit        = 1'b0;
      c.bit_src     = BIT_ZERO;
      c.cnt_load    = CNT_NONE;
      c.word_load   = WORD_NONE;
      c.start       = 1'b0;
      c.finish      = 1'b0;
      c.done_at_end = 1'b0;
      c.cond        = COND_ALWAYS;
      c.target      = STEP_IDLE;
      case (step)
         STEP_IDLE: begin
            c.wait_req = 1'b1;
            c.cond     = COND_IN_TRACK;
            c.target   = STEP_LOADC;
         end
         STEP_START: begin
            c.start    = 1'b1;
            c.cnt_load = CNT_LEAD;
            c.cond     = COND_ALWAYS;
            c.target   = STEP_PRE;
         end
         STEP_PRE: begin
            c.emit   = 1'b1;
            c.cond   = COND_CNT_NZ;
            c.target = STEP_PRE;
         end
         STEP_LOADC: begin
            c.word_load = WORD_CHAR;
            c.cnt_load  = CNT_NBITS;
            c.cond      = COND_ALWAYS;
            c.target    = STEP_BITS;
         end
         STEP_BITS: begin
            c.emit    = 1'b1;
            c.bit_src = BIT_WORD;
            c.cond    = COND_CNT_NZ;
            c.target  = STEP_BITS;
         end
         STEP_PAR: begin
            c.emit    = 1'b1;
            c.bit_src = BIT_PARITY;
            c.cond    = COND_NOT_LAST;
            c.target  = STEP_IDLE;
         end
         STEP_LOADL: begin
            c.word_load = WORD_LRC;
            c.cnt_load  = CNT_NBITS;
            c.cond      = COND_ALWAYS;
            c.target    = STEP_LBITS;
         end
         STEP_LBITS: begin
            c.emit    = 1'b1;
            c.bit_src = BIT_WORD;
            c.cond    = COND_CNT_NZ;
            c.target  = STEP_LBITS;
         end
         STEP_LPAR: begin
            c.emit     = 1'b1;
            c.bit_src  = BIT_PARITY;
            c.cnt_load = CNT_TRAIL;
            c.cond     = COND_ALWAYS;
            c.target   = STEP_TRAIL;
         end
         STEP_TRAIL: begin
            c.emit        = 1'b1;
            c.done_at_end = 1'b1;
            c.cond        = COND_CNT_NZ;
            c.target      = STEP_TRAIL;
         end
         STEP_END: begin
            c.finish = 1'b1;
            c.cond   = COND_ALWAYS;
            c.target = STEP_IDLE;
         end
         default: begin
            c.cond   = COND_ALWAYS;
            c.target = STEP_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

>>> hdl/msf2f_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msf2f channel interfaces
// Valid/ready channels for characters, bit cells and the track register.
// ----------------------------------------------------------------------------
interface msf2f_req_if;
   logic                          valid;
   logic                          ready;
   logic [msf2f_pkg::CHAR_W-1:0]  character;
   logic                          last_char;

   modport source (output valid, character, last_char, input ready);
   modport sink   (input valid, character, last_char, output ready);
endinterface

interface msf2f_rsp_if;
   logic valid;
   logic ready;
   logic cell_bit;
   logic first_half_level;
   logic second_half_level;
   logic swipe_done;

   modport source (output valid, cell_bit, first_half_level, second_half_level,
                   swipe_done, input ready);
   modport sink   (input valid, cell_bit, first_half_level, second_half_level,
                   swipe_done, output ready);
endinterface

interface msf2f_csr_if;
   logic valid;
   logic ready;
   logic track_select;

   modport source (output valid, track_select, input ready);
   modport sink   (input valid, track_select, output ready);
endinterface

>>> hdl/magstripe_track_f2f_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magstripe_track_f2f_encoder
// F2F (biphase) coil drive encoder for one magnetic-stripe track.
// ----------------------------------------------------------------------------
// Takes one track character per req beat and sends one rsp beat per bit cell.
// The first character of a track is preceded by LEADING_ZEROS zero cells (coil
// level and LRC cleared first). Each character goes out as its data bits, LSB
// first, plus odd parity: 6 bits on track one, 4 on track two (csr bit). A
// character with last_char set is followed by the LRC with its parity and 25
// trailing zero cells, the final one flagged swipe_done. A microcoded
// sequencer runs the job, one step per cycle unless a step waits for a req beat
// or for a free output slot, and one cell register feeds the output. Ready on
// req is high only while the sequencer sits in its fetch step; csr writes are
// always taken.
// ----------------------------------------------------------------------------
module magstripe_track_f2f_encoder #(
   parameter int LEADING_ZEROS = 25
) (
   input  logic               clock,
   input  logic               reset,
   msf2f_req_if.sink          req_chan,
   msf2f_rsp_if.source        rsp_chan,
   msf2f_csr_if.sink          csr_chan
);
   import msf2f_pkg::*;

   // control
   ctl_type   ctl;
   flags_type flags;
   logic      fire;

   // state
   logic              track_ff,    track_in;
   logic              coil_ff,     coil_in;
   logic [WORD_W-1:0] lrc_ff,      lrc_in;
   logic              in_track_ff, in_track_in;
   logic [CHAR_W-1:0] char_ff,     char_in;
   logic              last_ff,     last_in;
   logic [WORD_W-1:0] word_ff,     word_in;
   logic              parity_ff,   parity_in;
   logic [CNT_W-1:0]  cnt_ff,      cnt_in;

   // output cell register
   logic rsp_valid_ff, rsp_valid_in;
   logic bit_ff,       bit_in;
   logic first_ff,     first_in;
   logic second_ff,    second_in;
   logic done_ff,      done_in;

   // datapath terms
   logic [WORD_W-1:0] mask;
   logic [CHAR_W-1:0] offset;
   logic [CNT_W-1:0]  nbits;
   logic [CHAR_W-1:0] diff;
   logic [WORD_W-1:0] data;
   logic              cell_val;
   logic              lvl_first;
   logic              lvl_second;
   logic              out_free;

   msf2f_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl),
      .fire  (fire)
   );

   assign req_chan.ready = ctl.wait_req;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.cell_bit          = bit_ff;
   assign rsp_chan.first_half_level  = first_ff;
   assign rsp_chan.second_half_level = second_ff;
   assign rsp_chan.swipe_done        = done_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      flags.accept   = req_chan.valid && ctl.wait_req;
      flags.in_track = in_track_ff;
      flags.cnt_nz   = (cnt_ff != '0);
      flags.last     = last_ff;
      flags.out_free = out_free;
   end

   // track geometry
   assign mask   = track_ff ? MASK_T2   : MASK_T1;
   assign offset = track_ff ? OFFSET_T2 : OFFSET_T1;
   assign nbits  = track_ff ? NBITS_T2  : NBITS_T1;

   // subtract offset, keep data width (wraps below the offset)
   assign diff = char_ff - offset;
   assign data = diff[WORD_W-1:0] & mask;

   always_comb begin
      case (ctl.bit_src)
         BIT_ZERO:   cell_val = 1'b0;
         BIT_WORD:   cell_val = word_ff[0];
         BIT_PARITY: cell_val = parity_ff;
         default:    cell_val = 1'b0;
      endcase
   end

   // every cell flips at its start; a one flips again at mid-cell
   assign lvl_first  = !coil_ff;
   assign lvl_second = lvl_first ^ cell_val;

   always_comb begin
      track_in     = track_ff;
      coil_in      = coil_ff;
      lrc_in       = lrc_ff;
      in_track_in  = in_track_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      word_in      = word_ff;
      parity_in    = parity_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      bit_in       = bit_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      done_in      = done_ff;

      if (csr_chan.valid) begin
         track_in = csr_chan.track_select;
      end

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (fire) begin
         if (ctl.wait_req) begin
            char_in = req_chan.character;
            last_in = req_chan.last_char;
         end

         if (ctl.start) begin
            coil_in     = 1'b0;
            lrc_in      = '0;
            in_track_in = 1'b1;
         end

         if (ctl.finish) begin
            in_track_in = 1'b0;
         end

         case (ctl.word_load)
            WORD_CHAR: begin
               word_in   = data;
               lrc_in    = lrc_ff ^ data;
               parity_in = 1'b1;
            end
            WORD_LRC: begin
               word_in   = lrc_ff & mask;
               parity_in = 1'b1;
            end
            default: ;
         endcase

         if (ctl.emit) begin
            coil_in      = lvl_second;
            rsp_valid_in = 1'b1;
            bit_in       = cell_val;
            first_in     = lvl_first;
            second_in    = lvl_second;
            done_in      = ctl.done_at_end && (cnt_ff == '0);
            cnt_in       = cnt_ff - CNT_W'(1);
            if (ctl.bit_src == BIT_WORD) begin
               word_in   = word_ff >> 1;
               parity_in = parity_ff ^ cell_val;
            end
         end

         // a load wins over the per-cell countdown
         case (ctl.cnt_load)
            CNT_LEAD:  cnt_in = CNT_W'(LEADING_ZEROS - 1);
            CNT_NBITS: cnt_in = nbits - CNT_W'(1);
            CNT_TRAIL: cnt_in = CNT_W'(TRAIL_ZEROS - 1);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff     <= 1'b0;
         coil_ff      <= 1'b0;
         lrc_ff       <= '0;
         in_track_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         track_ff     <= track_in;
         coil_ff      <= coil_in;
         lrc_ff       <= lrc_in;
         in_track_ff  <= in_track_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      last_ff   <= last_in;
      word_ff   <= word_in;
      parity_ff <= parity_in;
      cnt_ff    <= cnt_in;
      bit_ff    <= bit_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      done_ff   <= done_in;
   end

endmodule

>>> hdl/msf2f_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msf2f_seq
// Step counter and microcode lookup; conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module msf2f_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  msf2f_pkg::flags_type flags,
   output msf2f_pkg::ctl_type   ctl,
   output logic                 fire
);
   import msf2f_pkg::*;

   step_type pc_ff;
   step_type pc_in;
   logic     take;

   always_comb ctl = ucode(pc_ff);

   always_comb begin
      case (ctl.cond)
         COND_ALWAYS:   take = 1'b1;
         COND_IN_TRACK: take = flags.in_track;
         COND_CNT_NZ:   take = flags.cnt_nz;
         COND_NOT_LAST: take = !flags.last;
         default:       take = 1'b1;
      endcase
   end

   // a step retires on an input beat, on a free output slot, or at once
   always_comb begin
      if (ctl.wait_req) begin
         fire = flags.accept;
      end else if (ctl.emit) begin
         fire = flags.out_free;
      end else begin
         fire = 1'b1;
      end
   end

   always_comb begin
      pc_in = pc_ff;
      if (fire) begin
         pc_in = take ? ctl.target : step_type'(STEP_W'(pc_ff) + STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
